FILE: hw/rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types for the modular exponentiation block: controller states,
// multiplier operand selection, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_RED_W,
    S_CHECK,
    S_RES_W,
    S_SQ_W,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    MUL_REDUCE,
    MUL_RES,
    MUL_SQ
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     exp_shift;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic exp_zero;
    logic exp_lsb;
    logic out_full;
  } sts_t;

endpackage

FILE: hw/rtl/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for square-and-multiply: reduces the base, then walks the
// exponent one bit at a time, issuing multiplies to the datapath.
// ----------------------------------------------------------------------------
module mexp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  output mexp_pkg::cmd_t cmd_o,
  input  mexp_pkg::sts_t sts_i
);
  import mexp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) state_d = S_RED;
      end
      S_RED:   state_d = S_RED_W;
      S_RED_W: begin
        if (!sts_i.mul_busy) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.exp_zero) begin
          state_d = S_DONE;
        end else if (sts_i.exp_lsb) begin
          state_d = S_RES_W;
        end else begin
          state_d = S_SQ_W;
        end
      end
      S_RES_W: begin
        if (!sts_i.mul_busy) state_d = S_SQ_W;
      end
      S_SQ_W: begin
        if (!sts_i.mul_busy) state_d = S_CHECK;
      end
      S_DONE: begin
        if (!sts_i.out_full) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready_o      = 1'b0;
    cmd_o.load      = 1'b0;
    cmd_o.mul_start = 1'b0;
    cmd_o.mul_sel   = MUL_REDUCE;
    cmd_o.exp_shift = 1'b0;
    cmd_o.out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.load = s_tvalid_i;
      end
      S_RED: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MUL_REDUCE;
      end
      S_RED_W: ;
      S_CHECK: begin
        if (!sts_i.exp_zero) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = sts_i.exp_lsb ? MUL_RES : MUL_SQ;
        end
      end
      S_RES_W: begin
        if (!sts_i.mul_busy) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_SQ;
        end
      end
      S_SQ_W: begin
        cmd_o.exp_shift = !sts_i.mul_busy;
      end
      S_DONE: begin
        cmd_o.out_load = !sts_i.out_full;
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/mexp_dp.sv
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: operand registers, exponent shifter, bit-serial modular
// multiplier (MSB first, partial sum kept below the modulus) and the
// result output register.
// ----------------------------------------------------------------------------
module mexp_dp #(
  parameter int WIDTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mexp_pkg::cmd_t     cmd_i,
  output mexp_pkg::sts_t     sts_o,
  input  logic [WIDTH-1:0]   base_value_i,
  input  logic [WIDTH-1:0]   exponent_i,
  input  logic [WIDTH-1:0]   modulus_i,
  input  logic               m_tready_i,
  output logic               out_valid_o,
  output logic [WIDTH-1:0]   power_result_o
);
  import mexp_pkg::*;

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] res_q, res_d;
  logic [WIDTH-1:0] sq_q, sq_d;
  logic [WIDTH-1:0] exp_q, exp_d;
  logic [WIDTH-1:0] mod_q, mod_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] mula_q, mula_d;
  logic [WIDTH-1:0] mulb_q, mulb_d;
  logic [WIDTH-1:0] out_q, out_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  mul_sel_e         sel_q, sel_d;
  logic             busy_q, busy_d;
  logic             phase_q, phase_d;
  logic             out_valid_q, out_valid_d;

  logic [WIDTH-1:0] add_y, room, add_sum;
  logic             advance, last;

  always_comb begin
    add_y   = phase_q ? mula_q : acc_q;
    room    = mod_q - add_y;
    add_sum = (acc_q >= room) ? (acc_q - room) : (acc_q + add_y);
  end

  always_comb begin
    res_d       = res_q;
    sq_d        = sq_q;
    exp_d       = exp_q;
    mod_d       = mod_q;
    acc_d       = acc_q;
    mula_d      = mula_q;
    mulb_d      = mulb_q;
    cnt_d       = cnt_q;
    sel_d       = sel_q;
    busy_d      = busy_q;
    phase_d     = phase_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~m_tready_i;
    advance     = 1'b0;
    last        = (cnt_q == '0);

    if (cmd_i.load) begin
      sq_d  = base_value_i;
      exp_d = exponent_i;
      mod_d = modulus_i;
      res_d = (modulus_i == WIDTH'(1)) ? '0 : WIDTH'(1);
    end

    if (cmd_i.exp_shift) begin
      exp_d = exp_q >> 1;
    end

    if (cmd_i.mul_start) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      acc_d   = '0;
      cnt_d   = CW'(WIDTH - 1);
      sel_d   = cmd_i.mul_sel;
      unique case (cmd_i.mul_sel)
        MUL_REDUCE: begin
          mula_d = WIDTH'(1);
          mulb_d = sq_q;
        end
        MUL_RES: begin
          mula_d = res_q;
          mulb_d = sq_q;
        end
        MUL_SQ: begin
          mula_d = sq_q;
          mulb_d = sq_q;
        end
        default: begin
          mula_d = sq_q;
          mulb_d = sq_q;
        end
      endcase
    end else if (busy_q) begin
      acc_d = add_sum;
      if (!phase_q && mulb_q[WIDTH-1]) begin
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        advance = 1'b1;
      end
      if (advance) begin
        mulb_d = mulb_q << 1;
        cnt_d  = cnt_q - CW'(1);
        if (last) begin
          busy_d = 1'b0;
          if (sel_q == MUL_RES) begin
            res_d = add_sum;
          end else begin
            sq_d = add_sum;
          end
        end
      end
    end

    if (cmd_i.out_load) begin
      out_d       = (mod_q == '0) ? '0 : res_q;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    sq_q   <= sq_d;
    exp_q  <= exp_d;
    mod_q  <= mod_d;
    acc_q  <= acc_d;
    mula_q <= mula_d;
    mulb_q <= mulb_d;
    cnt_q  <= cnt_d;
    sel_q  <= sel_d;
    out_q  <= out_d;
  end

  assign sts_o.mul_busy = busy_q;
  assign sts_o.exp_zero = (exp_q == '0);
  assign sts_o.exp_lsb  = exp_q[0];
  assign sts_o.out_full = out_valid_q & ~m_tready_i;

  assign out_valid_o    = out_valid_q;
  assign power_result_o = out_q;

endmodule

FILE: hw/rtl/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// Computes base_value ** exponent mod modulus by right-to-left binary
// square-and-multiply on one shared bit-serial modular multiplier.
//
// Usage:
//   Input stream (s_*): one transaction carries base, exponent and modulus.
//   Output stream (m_*): one transaction carries the result.
//   Each input transaction gives exactly one output transaction, in order.
//   A multiply doubles the partial sum for each bit of its second operand,
//   MSB first, and adds the first operand for each set bit; its wait state
//   ends once the multiplier goes idle.
//   From input accept to output valid the controller reduces the base, then
//   for each exponent bit up to the highest set one checks the bit and
//   squares, preceded by a multiply into the result for a set bit, and
//   finally moves the result into the output register.
//   The next item is accepted once the result has moved into the output
//   register, so a result waiting on m_tready does not block the following
//   input; a second result waits inside until the first leaves.
//   Reset clears control state only; no state is kept between items.
//   A modulus of zero returns zero.
// ----------------------------------------------------------------------------
module modular_exponentiation_top #(
  parameter int WIDTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_tvalid_i,
  output logic                                 s_tready_o,
  // tdata fields from bit 0: base_value, exponent, modulus, zero padding
  input  logic [((3*WIDTH+7)/8)*8-1:0]         s_tdata_i,
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  // tdata fields from bit 0: power_result, zero padding
  output logic [((WIDTH+7)/8)*8-1:0]           m_tdata_o
);
  import mexp_pkg::*;

  localparam int OUT_W = ((WIDTH + 7) / 8) * 8;

  cmd_t             cmd;
  sts_t             sts;
  logic [WIDTH-1:0] power_result;

  mexp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  mexp_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .base_value_i   (s_tdata_i[WIDTH-1:0]),
    .exponent_i     (s_tdata_i[2*WIDTH-1:WIDTH]),
    .modulus_i      (s_tdata_i[3*WIDTH-1:2*WIDTH]),
    .m_tready_i     (m_tready_i),
    .out_valid_o    (m_tvalid_o),
    .power_result_o (power_result)
  );

  assign m_tdata_o = OUT_W'(power_result);

endmodule

FILE: hw/rtl/mexp_checker.sv
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks for the modular exponentiation block, bound to the top.
// ----------------------------------------------------------------------------
module mexp_checker #(
  parameter int WIDTH = 64
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_tvalid_i,
  input logic                         s_tready_o,
  input logic                         m_tvalid_o,
  input logic                         m_tready_i,
  input logic [((WIDTH+7)/8)*8-1:0]   m_tdata_o
);

  logic s_acc;
  assign s_acc = s_tvalid_i && s_tready_o;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_tready_o)
    else $error("input accepted again right after a transaction");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !$rose(m_tvalid_o))
    else $error("result appeared right after accepting an input");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o)
    else $error("output valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> $stable(m_tdata_o))
    else $error("output data changed while stalled");

endmodule

bind modular_exponentiation_top mexp_checker #(.WIDTH(WIDTH)) u_mexp_checker (.*);
